[design/boec_pkg.sv]
// ---------------------------------------------------------------------------
// boec_pkg: shared definitions for the Belady eviction counter
// Field widths, default sizes and the back-end state encoding.
// ---------------------------------------------------------------------------
package boec_pkg;

    localparam int DEF_MAX_REQUESTS = 128;
    localparam int DEF_ID_COUNT     = 128;

    localparam int ITEM_ID_W = 7;
    localparam int SLOT_W    = 8;
    localparam int COUNT_W   = 8;

    localparam logic [SLOT_W-1:0]  SLOT_RESET = 8'd1;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'd255;

    typedef enum logic [3:0] {
        BK_LOAD,
        BK_CLR,
        BK_NP_RD,
        BK_NP_SEEN,
        BK_NP_WR,
        BK_RP_RD,
        BK_RP_RES,
        BK_RP_CHK,
        BK_SC_RD,
        BK_SC_EV,
        BK_SC_EVICT,
        BK_SC_FILL,
        BK_DONE
    } boec_state_t;

endpackage

[design/boec_ifs.sv]
// ---------------------------------------------------------------------------
// boec_ifs: request and result stream channels
// Valid/ready channels carrying one request beat or one result beat.
// ---------------------------------------------------------------------------
interface boec_req_if import boec_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ITEM_ID_W-1:0] item_id;
    logic                 last_request;

    modport source (output valid, output item_id, output last_request, input ready);
    modport sink   (input valid, input item_id, input last_request, output ready);
endinterface

interface boec_res_if import boec_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] eviction_count;
    logic               overflow;

    modport source (output valid, output eviction_count, output overflow, input ready);
    modport sink   (input valid, input eviction_count, input overflow, output ready);
endinterface

[design/boec_front.sv]
// ---------------------------------------------------------------------------
// boec_front: request intake
// Accepts request beats, wraps ids, assigns buffer slots and flags drops.
// ---------------------------------------------------------------------------
module boec_front
    import boec_pkg::*;
#(
    parameter int MAX_REQUESTS = DEF_MAX_REQUESTS,
    parameter int ID_COUNT     = DEF_ID_COUNT,
    localparam int IdW  = $clog2(ID_COUNT),
    localparam int IdxW = $clog2(MAX_REQUESTS),
    localparam int PosW = $clog2(MAX_REQUESTS + 1),
    localparam int EntW = IdW + IdxW + 3 + PosW
)
(
    input  logic            clk,
    input  logic            rst_n,
    boec_req_if.sink        req,
    output logic            q_valid,
    input  logic            q_ready,
    output logic [EntW-1:0] q_data
);

    localparam int RecipSh = 14;
    localparam int ProdW   = ITEM_ID_W + RecipSh;
    localparam logic [ProdW-1:0] ID_RECIP =
        ProdW'(((1 << RecipSh) + ID_COUNT - 1) / ID_COUNT);

    logic [PosW-1:0]      cnt_reg, cnt_next;
    logic                 drop_reg, drop_next;
    logic                 store;
    logic                 ovf;
    logic [PosW-1:0]      cnt_after;
    logic [ProdW-1:0]     id_prod;
    logic [ITEM_ID_W-1:0] id_quot;
    logic [ITEM_ID_W-1:0] id_rem;
    logic [IdW-1:0]       id_mod;
    logic                 accept;

    always_comb
    begin
        store     = cnt_reg < PosW'(MAX_REQUESTS);
        cnt_after = store ? cnt_reg + PosW'(1) : cnt_reg;
        ovf       = drop_reg | ~store;
        id_prod   = ProdW'(req.item_id) * ID_RECIP;
        id_quot   = id_prod[ProdW-1:RecipSh];
        id_rem    = req.item_id - ITEM_ID_W'(32'(id_quot) * ID_COUNT);
        id_mod    = IdW'(id_rem);
        accept    = req.valid & q_ready;
        cnt_next  = cnt_reg;
        drop_next = drop_reg;
        if (accept)
        begin
            if (req.last_request)
            begin
                cnt_next  = '0;
                drop_next = 1'b0;
            end
            else
            begin
                cnt_next  = cnt_after;
                drop_next = ovf;
            end
        end
    end

    assign req.ready = q_ready;
    assign q_valid   = req.valid;
    assign q_data    = {id_mod, cnt_reg[IdxW-1:0], store, req.last_request, ovf, cnt_after};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            drop_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            drop_reg <= drop_next;
        end
    end

endmodule

[design/boec_queue.sv]
// ---------------------------------------------------------------------------
// boec_queue: two-entry decoupling queue
// Holds classified request beats between the front and the back.
// ---------------------------------------------------------------------------
module boec_queue
    import boec_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push;
    logic             pop;

    always_comb
    begin
        in_ready    = count_reg != 2'd2;
        out_valid   = count_reg != 2'd0;
        out_data    = entry_reg[rd_ptr_reg];
        push        = in_valid & in_ready;
        pop         = out_valid & out_ready;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[design/boec_back.sv]
// ---------------------------------------------------------------------------
// boec_back: sequence store and optimal replacement replay
// Stores requests, builds next-use links, replays with farthest-use eviction.
// ---------------------------------------------------------------------------
module boec_back
    import boec_pkg::*;
#(
    parameter int MAX_REQUESTS = DEF_MAX_REQUESTS,
    parameter int ID_COUNT     = DEF_ID_COUNT,
    localparam int IdW  = $clog2(ID_COUNT),
    localparam int IdxW = $clog2(MAX_REQUESTS),
    localparam int PosW = $clog2(MAX_REQUESTS + 1),
    localparam int RtW  = $clog2(ID_COUNT + 1),
    localparam int CmpW = (RtW > SLOT_W) ? RtW : SLOT_W,
    localparam int EntW = IdW + IdxW + 3 + PosW
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SLOT_W-1:0] slot_count,
    input  logic              q_valid,
    output logic              q_ready,
    input  logic [EntW-1:0]   q_data,
    boec_res_if.source        res
);

    localparam logic [IdW-1:0] ID_LAST = IdW'(ID_COUNT - 1);

    logic [IdW-1:0]  buf_mem  [MAX_REQUESTS];
    logic [PosW-1:0] np_mem   [MAX_REQUESTS];
    logic [PosW:0]   seen_mem [ID_COUNT];
    logic [PosW:0]   res_mem  [ID_COUNT];

    logic [IdW-1:0]  buf_rdata_reg;
    logic [PosW-1:0] np_rdata_reg;
    logic [PosW:0]   seen_rdata_reg;
    logic [PosW:0]   res_rdata_reg;

    logic            buf_we;
    logic [IdxW-1:0] buf_waddr;
    logic [IdW-1:0]  buf_wdata;
    logic            np_we;
    logic [PosW-1:0] np_wdata;
    logic            seen_we;
    logic [IdW-1:0]  seen_waddr;
    logic [PosW:0]   seen_wdata;
    logic            res_we;
    logic [IdW-1:0]  res_waddr;
    logic [PosW:0]   res_wdata;
    logic [IdW-1:0]  res_raddr;

    boec_state_t       state_reg, state_next;
    logic [IdxW-1:0]   idx_reg, idx_next;
    logic [IdW-1:0]    id_cnt_reg, id_cnt_next;
    logic [PosW-1:0]   total_reg, total_next;
    logic              ovf_reg, ovf_next;
    logic [RtW-1:0]    rt_reg, rt_next;
    logic [COUNT_W-1:0] evict_reg, evict_next;
    logic [PosW-1:0]   best_reg, best_next;
    logic [IdW-1:0]    victim_reg, victim_next;
    logic              out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] out_count_reg;
    logic              out_ovf_reg;
    logic              out_load;

    logic [PosW-1:0]   e_total;
    logic              e_ovf;
    logic              e_last;
    logic              e_store;
    logic [IdxW-1:0]   e_pos;
    logic [IdW-1:0]    e_id;
    logic [SLOT_W-1:0] slots;
    logic              at_end;

    assign e_total = q_data[PosW-1:0];
    assign e_ovf   = q_data[PosW];
    assign e_last  = q_data[PosW+1];
    assign e_store = q_data[PosW+2];
    assign e_pos   = q_data[PosW+3 +: IdxW];
    assign e_id    = q_data[PosW+3+IdxW +: IdW];

    assign slots  = (slot_count == '0) ? SLOT_W'(1) : slot_count;
    assign at_end = PosW'(idx_reg) == total_reg - PosW'(1);

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        id_cnt_next = id_cnt_reg;
        total_next  = total_reg;
        ovf_next    = ovf_reg;
        rt_next     = rt_reg;
        evict_next  = evict_reg;
        best_next   = best_reg;
        victim_next = victim_reg;
        out_load    = 1'b0;
        q_ready     = 1'b0;
        buf_we      = 1'b0;
        buf_waddr   = e_pos;
        buf_wdata   = e_id;
        np_we       = 1'b0;
        np_wdata    = seen_rdata_reg[PosW] ? seen_rdata_reg[PosW-1:0] : total_reg;
        seen_we     = 1'b0;
        seen_waddr  = buf_rdata_reg;
        seen_wdata  = {1'b1, PosW'(idx_reg)};
        res_we      = 1'b0;
        res_waddr   = buf_rdata_reg;
        res_wdata   = {1'b1, np_rdata_reg};
        res_raddr   = buf_rdata_reg;

        unique case (state_reg)
            BK_LOAD:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    buf_we = e_store;
                    if (e_last)
                    begin
                        total_next  = e_total;
                        ovf_next    = e_ovf;
                        evict_next  = '0;
                        rt_next     = '0;
                        id_cnt_next = '0;
                        state_next  = (e_total == '0) ? BK_DONE : BK_CLR;
                    end
                end
            end
            BK_CLR:
            begin
                seen_we    = 1'b1;
                seen_waddr = id_cnt_reg;
                seen_wdata = '0;
                res_we     = 1'b1;
                res_waddr  = id_cnt_reg;
                res_wdata  = '0;
                if (id_cnt_reg == ID_LAST)
                begin
                    idx_next   = IdxW'(total_reg - PosW'(1));
                    state_next = BK_NP_RD;
                end
                else
                begin
                    id_cnt_next = id_cnt_reg + IdW'(1);
                end
            end
            BK_NP_RD:
            begin
                state_next = BK_NP_SEEN;
            end
            BK_NP_SEEN:
            begin
                state_next = BK_NP_WR;
            end
            BK_NP_WR:
            begin
                np_we   = 1'b1;
                seen_we = 1'b1;
                if (idx_reg == '0)
                begin
                    state_next = BK_RP_RD;
                end
                else
                begin
                    idx_next   = idx_reg - IdxW'(1);
                    state_next = BK_NP_RD;
                end
            end
            BK_RP_RD:
            begin
                state_next = BK_RP_RES;
            end
            BK_RP_RES:
            begin
                state_next = BK_RP_CHK;
            end
            BK_RP_CHK:
            begin
                if (res_rdata_reg[PosW] || (CmpW'(rt_reg) < CmpW'(slots)))
                begin
                    res_we = 1'b1;
                    if (!res_rdata_reg[PosW])
                    begin
                        rt_next = rt_reg + RtW'(1);
                    end
                    if (at_end)
                    begin
                        state_next = BK_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IdxW'(1);
                        state_next = BK_RP_RD;
                    end
                end
                else
                begin
                    id_cnt_next = '0;
                    best_next   = '0;
                    state_next  = BK_SC_RD;
                end
            end
            BK_SC_RD:
            begin
                res_raddr  = id_cnt_reg;
                state_next = BK_SC_EV;
            end
            BK_SC_EV:
            begin
                res_raddr = id_cnt_reg;
                if (res_rdata_reg[PosW] && (res_rdata_reg[PosW-1:0] >= best_reg))
                begin
                    best_next   = res_rdata_reg[PosW-1:0];
                    victim_next = id_cnt_reg;
                end
                if (id_cnt_reg == ID_LAST)
                begin
                    state_next = BK_SC_EVICT;
                end
                else
                begin
                    id_cnt_next = id_cnt_reg + IdW'(1);
                    state_next  = BK_SC_RD;
                end
            end
            BK_SC_EVICT:
            begin
                res_we     = 1'b1;
                res_waddr  = victim_reg;
                res_wdata  = '0;
                state_next = BK_SC_FILL;
            end
            BK_SC_FILL:
            begin
                res_we = 1'b1;
                if (evict_reg != COUNT_MAX)
                begin
                    evict_next = evict_reg + COUNT_W'(1);
                end
                if (at_end)
                begin
                    state_next = BK_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + IdxW'(1);
                    state_next = BK_RP_RD;
                end
            end
            BK_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_load   = 1'b1;
                    state_next = BK_LOAD;
                end
            end
            default:
            begin
                state_next = BK_LOAD;
            end
        endcase

        out_valid_next = (out_valid_reg & ~res.ready) | out_load;
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[buf_waddr] <= buf_wdata;
        end
        buf_rdata_reg <= buf_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (np_we)
        begin
            np_mem[idx_reg] <= np_wdata;
        end
        np_rdata_reg <= np_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (seen_we)
        begin
            seen_mem[seen_waddr] <= seen_wdata;
        end
        seen_rdata_reg <= seen_mem[buf_rdata_reg];
    end

    always_ff @(posedge clk)
    begin
        if (res_we)
        begin
            res_mem[res_waddr] <= res_wdata;
        end
        res_rdata_reg <= res_mem[res_raddr];
    end

    always_ff @(posedge clk)
    begin
        best_reg   <= best_next;
        victim_reg <= victim_next;
        if (out_load)
        begin
            out_count_reg <= evict_reg;
            out_ovf_reg   <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_LOAD;
            idx_reg       <= '0;
            id_cnt_reg    <= '0;
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            rt_reg        <= '0;
            evict_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            id_cnt_reg    <= id_cnt_next;
            total_reg     <= total_next;
            ovf_reg       <= ovf_next;
            rt_reg        <= rt_next;
            evict_reg     <= evict_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.eviction_count = out_count_reg;
    assign res.overflow       = out_ovf_reg;

endmodule

[design/belady_optimal_eviction_counter_top.sv]
// Loading: one request beat per cycle through a two-entry queue in BK_LOAD.
// Replay after the last beat: clear the resident and last-use maps, build
// next-use links for the stored requests, replay each request, and scan
// every id for the victim on each eviction.
// Result: held in an output register; loading resumes while it waits.
// Reset: asynchronous, active low; clears control state, slot_count to 1.
// ---------------------------------------------------------------------------
// belady_optimal_eviction_counter_top: optimal replacement eviction counter
// Front intake, decoupling queue and replay back end with slot_count register.
// ---------------------------------------------------------------------------
module belady_optimal_eviction_counter_top
    import boec_pkg::*;
#(
    parameter int MAX_REQUESTS = DEF_MAX_REQUESTS,
    parameter int ID_COUNT     = DEF_ID_COUNT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [SLOT_W-1:0] cfg_data,
    boec_req_if.sink          req,
    boec_res_if.source        res
);

    localparam int IdW  = $clog2(ID_COUNT);
    localparam int IdxW = $clog2(MAX_REQUESTS);
    localparam int PosW = $clog2(MAX_REQUESTS + 1);
    localparam int EntW = IdW + IdxW + 3 + PosW;

    logic [SLOT_W-1:0] slot_count_reg;
    logic              fq_valid;
    logic              fq_ready;
    logic [EntW-1:0]   fq_data;
    logic              qb_valid;
    logic              qb_ready;
    logic [EntW-1:0]   qb_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= SLOT_RESET;
        end
        else if (cfg_write)
        begin
            slot_count_reg <= cfg_data;
        end
    end

    boec_front #(
        .MAX_REQUESTS (MAX_REQUESTS),
        .ID_COUNT     (ID_COUNT)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_data  (fq_data)
    );

    boec_queue #(
        .WIDTH (EntW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    boec_back #(
        .MAX_REQUESTS (MAX_REQUESTS),
        .ID_COUNT     (ID_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .slot_count (slot_count_reg),
        .q_valid    (qb_valid),
        .q_ready    (qb_ready),
        .q_data     (qb_data),
        .res        (res)
    );

endmodule
